>>> hdl/sorted_value_table_macros.svh
// Assertion macros for the sorted value table RTL (used by svt_datapath).
`ifndef SORTED_VALUE_TABLE_MACROS_SVH
`define SORTED_VALUE_TABLE_MACROS_SVH

// Condition holds at every clock edge out of reset (uses clk and rst_n in scope).
`define SVT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define SVT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/svt_pkg.sv
// Shared types and constants for the sorted value table.
`default_nettype none

package svt_pkg;

    // Default table size and fixed field widths
    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OPC_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 16;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Pointer update
    typedef enum logic [2:0] {
        PTR_HOLD = 3'd0,
        PTR_ZERO = 3'd1,
        PTR_LAST = 3'd2,
        PTR_INC  = 3'd3,
        PTR_DEC  = 3'd4
    } ptr_op_t;

    // Write address select, relative to the pointer
    typedef enum logic [1:0] {
        WA_PTR = 2'd0,
        WA_INC = 2'd1,
        WA_DEC = 2'd2
    } wa_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                load_req;
        ptr_op_t             ptr_op;
        logic                we;
        wa_sel_t             wa_sel;
        logic                wd_key;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             cnt_zero;
        logic             full;
        logic             ptr_zero;
        logic             ptr_last;
        logic             rd_lt;
        logic             rd_eq;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/svt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module svt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/svt_ctrl.sv
// Operation sequencer for the sorted value table.
`default_nettype none

module svt_ctrl import svt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t st,
    output dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DISPATCH  = 7'b0000010,
        S_INS_WALK  = 7'b0000100,
        S_INS_PUT   = 7'b0001000,
        S_FIND      = 7'b0010000,
        S_DEL_SHIFT = 7'b0100000,
        S_DONE      = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // State and pending status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.wa_sel     = WA_PTR;
        cmd.out_status = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (st.op) inside
                    OP_INSERT:
                    begin
                        if (st.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (st.cnt_zero)
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            // walk down from the last held entry
                            cmd.ptr_op = PTR_LAST;
                            state_next = S_INS_WALK;
                        end
                    end
                    OP_LOOKUP, OP_DELETE:
                    begin
                        if (st.cnt_zero)
                        begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_FIND;
                        end
                    end
                    default:
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_DONE;
                    end
                endcase
            end

            // Shift entries not below the key up one slot until the gap is in place
            S_INS_WALK:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = WA_INC;
                if (st.rd_lt)
                begin
                    cmd.wd_key  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else if (st.ptr_zero)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end

            S_INS_PUT:
            begin
                cmd.we      = 1'b1;
                cmd.wa_sel  = WA_PTR;
                cmd.wd_key  = 1'b1;
                cmd.cnt_inc = 1'b1;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            // Scan up for the first entry not below the key
            S_FIND:
            begin
                if (st.rd_lt)
                begin
                    if (st.ptr_last)
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                    end
                end
                else if (st.rd_eq)
                begin
                    status_next = ST_OK;
                    if (st.op == OP_LOOKUP)
                    begin
                        state_next = S_DONE;
                    end
                    else if (st.ptr_last)
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_op = PTR_INC;
                        state_next = S_DEL_SHIFT;
                    end
                end
                else
                begin
                    status_next = ST_ABSENT;
                    state_next  = S_DONE;
                end
            end

            // Close the gap: move each later entry down one slot
            S_DEL_SHIFT:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = WA_DEC;
                if (st.ptr_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end

            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/svt_datapath.sv
// Table storage, walk pointer, count and result register.
`default_nettype none
`include "sorted_value_table_macros.svh"

module svt_datapath import svt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [OPC_W-1:0]  opcode,
    input  wire logic [DATA_W-1:0] value,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               st,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_W-1:0]     entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] key_reg;
    logic [OPC_W-1:0]         op_reg;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            cnt_reg;
    logic                     m_tvalid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [AW-1:0]            waddr;
    logic [DATA_W-1:0]        wdata;
    logic signed [DATA_W-1:0] rdata;

    // Pointer next value; the RAM reads at it so rdata follows ptr_reg
    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_LAST: ptr_next = AW'(cnt_reg - CW'(1));
            PTR_INC:  ptr_next = ptr_reg + AW'(1);
            PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    // Write address and data
    always_comb
    begin
        unique case (cmd.wa_sel)
            WA_PTR:  waddr = ptr_reg;
            WA_INC:  waddr = ptr_reg + AW'(1);
            WA_DEC:  waddr = ptr_reg - AW'(1);
            default: waddr = ptr_reg;
        endcase
    end

    assign wdata = cmd.wd_key ? key_reg : rdata;

    svt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_next),
        .rdata (rdata)
    );

    // Request capture and walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg <= value;
            op_reg  <= opcode;
        end
        ptr_reg <= ptr_next;
    end

    // Held entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // Result register; count is taken after this operation's update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            count_reg  <= COUNT_W'(cnt_reg);
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    // Status to the controller
    assign st.op       = op_reg;
    assign st.cnt_zero = (cnt_reg == '0);
    assign st.full     = (cnt_reg == CW'(CAPACITY));
    assign st.ptr_zero = (ptr_reg == '0);
    assign st.ptr_last = ((CW'(ptr_reg) + CW'(1)) == cnt_reg);
    assign st.rd_lt    = (rdata < key_reg);
    assign st.rd_eq    = (rdata == key_reg);
    assign st.out_free = !m_tvalid_reg || m_tready;

    `SVT_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(CAPACITY), "count above capacity")
    `SVT_ASSERT_IMPLY(a_inc_room, cmd.cnt_inc, cnt_reg < CW'(CAPACITY), "insert into full table")
    `SVT_ASSERT_IMPLY(a_dec_held, cmd.cnt_dec, cnt_reg != '0, "delete from empty table")
    `SVT_ASSERT_IMPLY(a_out_free, cmd.out_load, !m_tvalid_reg || m_tready, "result overwritten")

endmodule

`default_nettype wire

>>> hdl/sorted_value_table.sv
// Top level of the sorted value table.
// Holds up to CAPACITY signed 32-bit values in ascending order, duplicates allowed.
// Input stream s_*: one beat per operation: insert, look up or delete a value.
// Output stream m_*: one beat per operation with a status and the count held after it.
// Status: 0 done or found, 1 value not present (also for the unused opcode), 2 table full.
// Operations run one at a time; s_tready is high only while no operation is in progress.
// Steps of each operation after the input beat is taken:
//   insert: walk down from the last held entry, moving each entry not below the value up;
//   look up / delete: scan up for the first entry not below the value, then on delete
//   move each later entry down; a full table or an empty-table search skips the walk.
// The next input beat can be taken once the block is back in idle after loading the
// result register, so each operation starts when the one before it has finished.
// The walk is set by the single read and single write port of the entry RAM, one entry
// per cycle.
// The result sits in an output register: a new input beat is taken while an earlier
// result waits; a finished operation holds until the receiver frees that register.
// Reset (rst_n low, asynchronous) empties the table and drops any pending result; the
// entry RAM itself is not cleared, only entries below the count are ever read.
`default_nettype none

module sorted_value_table import svt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [1:0] opcode, [33:2] value, rest zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [1:0] status, [8:2] entry_count, rest zero
);

    dp_cmd_t             cmd;
    dp_stat_t            st;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    svt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    svt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (s_tdata[OPC_W-1:0]),
        .value       (s_tdata[OPC_W+DATA_W-1:OPC_W]),
        .cmd         (cmd),
        .st          (st),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .status      (status),
        .entry_count (entry_count)
    );

    // Pack the result beat
    assign m_tdata = {{(M_TDATA_W-COUNT_W-STATUS_W){1'b0}}, entry_count, status};

endmodule

`default_nettype wire

>>> verif/tb_sorted_value_table.sv
// Testbench for the sorted value table: random stream traffic checked against a table predictor.
module tb_sorted_value_table import svt_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int TABLE_SIZE  = CAPACITY_DEF;
    localparam int ITEM_TARGET = 1100;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = TABLE_SIZE + 20;

    // Opcode the block must treat as a no-op
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] value;
        bit                       wait_idle;   // hold off until all results are back
    } table_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } table_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Stimulus and checking state
    table_op_t                op_queue[$];
    table_result_t            pending_results[$];
    logic signed [DATA_W-1:0] ins_log[$];
    int                       failures = 0;
    int                       quiet_cycles = 0;
    int                       tx_gap = 0;
    int                       tx_calm = 0;
    int                       rx_stall = 0;
    int                       rx_calm = 0;

    // Predictor copy of the table
    logic signed [DATA_W-1:0] table_vals[TABLE_SIZE];
    int                       table_held = 0;

    sorted_value_table #(
        .CAPACITY(TABLE_SIZE)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one operation to the predicted table and return the expected beat
    function automatic table_result_t apply_table_op(table_op_t op);
        table_result_t res;
        int            pos;
        res.status = ST_ABSENT;
        pos = 0;
        while (pos < table_held && table_vals[pos] < op.value)
            pos++;
        case (op.opcode)
            OP_INSERT:
            begin
                if (table_held >= TABLE_SIZE)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = table_held; i > pos; i--)
                        table_vals[i] = table_vals[i - 1];
                    table_vals[pos] = op.value;
                    table_held++;
                    res.status = ST_OK;
                end
            end
            OP_LOOKUP:
            begin
                if (pos < table_held && table_vals[pos] == op.value)
                    res.status = ST_OK;
            end
            OP_DELETE:
            begin
                if (pos < table_held && table_vals[pos] == op.value)
                begin
                    for (int i = pos; i + 1 < table_held; i++)
                        table_vals[i] = table_vals[i + 1];
                    table_held--;
                    res.status = ST_OK;
                end
            end
            default:
                res.status = ST_ABSENT;
        endcase
        res.count = table_held[COUNT_W-1:0];
        return res;
    endfunction

    // Idle length: mostly short, a few long, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // Operand: extremes, values near zero, or anything
    function automatic logic signed [DATA_W-1:0] draw_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh8000_0001;
                3: return 32'sh7FFF_FFFE;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        if (r < 4)
            return $signed($urandom_range(0, 40)) - 32'sd20;
        return $signed($urandom());
    endfunction

    // A value inserted earlier, so lookups and deletes hit and duplicates appear
    function automatic logic signed [DATA_W-1:0] pick_logged();
        if (ins_log.size() == 0)
            return draw_value();
        return ins_log[$urandom_range(0, ins_log.size() - 1)];
    endfunction

    function automatic void queue_op(logic [OPC_W-1:0] opcode, logic signed [DATA_W-1:0] value,
                                     bit wait_idle);
        table_op_t op;
        op.opcode    = opcode;
        op.value     = value;
        op.wait_idle = wait_idle;
        op_queue.insert(op_queue.size(), op);
        if (opcode == OP_INSERT)
            ins_log.insert(ins_log.size(), value);
    endfunction

    // Sender: present the front of the queue, predict on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin : tx_side
        table_result_t want;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                want = apply_table_op(op_queue.pop_front());
                pending_results.insert(pending_results.size(), want);
                tx_gap = draw_gap(tx_calm);
            end
            if (s_tvalid && !s_tready)
                ;  // beat stays on the bus until taken
            else if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (op_queue.size() > 0
                     && !(op_queue[0].wait_idle && pending_results.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W - DATA_W - OPC_W){1'b0}},
                             op_queue[0].value, op_queue[0].opcode};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        table_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status,
                                 m_tdata[STATUS_W-1:0]);
                        failures++;
                    end
                    if (m_tdata[STATUS_W +: COUNT_W] !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d", $time, want.count,
                                 m_tdata[STATUS_W +: COUNT_W]);
                        failures++;
                    end
                    if (m_tdata[M_TDATA_W-1:STATUS_W+COUNT_W] !== '0)
                    begin
                        $display("%0t: tdata padding expected 0, got %h", $time,
                                 m_tdata[M_TDATA_W-1:STATUS_W+COUNT_W]);
                        failures++;
                    end
                end
                rx_stall = draw_gap(rx_calm);
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[sorted_value_table] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                       era_fill;
        int                       r;
        int                       idx;
        logic signed [DATA_W-1:0] v;

        // Directed: empty table, extremes, duplicates, misses, unused opcode
        queue_op(OP_LOOKUP, 32'sd5, 1'b0);
        queue_op(OP_DELETE, 32'sd5, 1'b0);
        queue_op(OP_UNUSED, 32'sd5, 1'b0);
        queue_op(OP_INSERT, 32'sd0, 1'b0);
        queue_op(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
        queue_op(OP_INSERT, 32'sh8000_0000, 1'b0);
        queue_op(OP_INSERT, -32'sd1, 1'b0);
        queue_op(OP_INSERT, 32'sd0, 1'b0);
        queue_op(OP_INSERT, 32'sd1, 1'b0);
        queue_op(OP_LOOKUP, 32'sh8000_0000, 1'b0);
        queue_op(OP_LOOKUP, 32'sh7FFF_FFFF, 1'b0);
        queue_op(OP_LOOKUP, 32'sd2, 1'b0);
        queue_op(OP_DELETE, 32'sd0, 1'b0);
        queue_op(OP_LOOKUP, 32'sd0, 1'b0);
        queue_op(OP_DELETE, 32'sd0, 1'b0);
        queue_op(OP_LOOKUP, 32'sd0, 1'b0);
        queue_op(OP_DELETE, 32'sd0, 1'b0);
        queue_op(OP_UNUSED, 32'sd1, 1'b0);
        queue_op(OP_DELETE, 32'sh7FFF_FFFF, 1'b0);
        queue_op(OP_DELETE, 32'sh8000_0000, 1'b0);
        queue_op(OP_DELETE, -32'sd1, 1'b0);
        queue_op(OP_DELETE, 32'sd1, 1'b0);
        ins_log.delete();

        // Random eras: fill (first one to full), mixed traffic, then drain to empty
        while (op_queue.size() < ITEM_TARGET)
        begin
            era_fill = (op_queue.size() < 100) ? 80 : $urandom_range(30, 80);
            while (era_fill > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    if ($urandom_range(0, 3) == 0)
                        queue_op(OP_INSERT, pick_logged(), 1'b0);
                    else
                        queue_op(OP_INSERT, draw_value(), 1'b0);
                    era_fill--;
                end
                else if (r < 90)
                    queue_op(OP_LOOKUP, $urandom_range(0, 1) ? pick_logged() : draw_value(), 1'b0);
                else if (r < 97)
                    queue_op(OP_DELETE, draw_value(), 1'b0);
                else
                    queue_op(OP_UNUSED, draw_value(), 1'b0);
            end

            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                v = ($urandom_range(0, 9) < 7) ? pick_logged() : draw_value();
                if (r < 35)
                    queue_op(OP_INSERT, $urandom_range(0, 1) ? pick_logged() : draw_value(),
                             n == 0);
                else if (r < 70)
                    queue_op(OP_LOOKUP, v, n == 0);
                else if (r < 95)
                    queue_op(OP_DELETE, v, n == 0);
                else
                    queue_op(OP_UNUSED, v, n == 0);
            end

            // Delete every value ever inserted once: the table ends empty
            queue_op(OP_LOOKUP, pick_logged(), 1'b1);
            while (ins_log.size() > 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_op(OP_LOOKUP, $urandom_range(0, 1) ? pick_logged() : draw_value(), 1'b0);
                else
                begin
                    idx = $urandom_range(0, ins_log.size() - 1);
                    v = ins_log[idx];
                    ins_log.delete(idx);
                    queue_op(OP_DELETE, v, 1'b0);
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && pending_results.size() == 0)
            $display("[sorted_value_table] OK");
        else
            $display("[sorted_value_table] ERROR");
        $finish;
    end

endmodule
